// ===== rtl/image_resize_nearest_and_box_blur_defines.svh =====
// assertion macros for the image scaler
`ifndef IMAGE_RESIZE_NEAREST_AND_BOX_BLUR_DEFINES_SVH
`define IMAGE_RESIZE_NEAREST_AND_BOX_BLUR_DEFINES_SVH

// condition implies consequence in the same cycle
`define IRNBB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define IRNBB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/irnbb_pkg.sv =====
// shared types, codes and helpers for the image scaler
package irnbb_pkg;

  // largest image side in pixels
  localparam int MAX_DIM = 128;

  // register indexes
  localparam logic [2:0] CFG_SRC_W  = 3'd0;
  localparam logic [2:0] CFG_SRC_H  = 3'd1;
  localparam logic [2:0] CFG_DST_W  = 3'd2;
  localparam logic [2:0] CFG_DST_H  = 3'd3;
  localparam logic [2:0] CFG_MODE   = 3'd4;

  // scale modes
  localparam logic [1:0] MODE_NEAREST = 2'd0;
  localparam logic [1:0] MODE_BLUR    = 2'd1;
  localparam logic [1:0] MODE_POT     = 2'd2;

  // request function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_OUT  = 1'b1;

  localparam int FIFO_DEPTH = 2;
  localparam int NUM_TAPS   = 5;

  typedef struct packed {
    logic        func;
    logic [31:0] pixel_word;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic       last_pixel;
    logic [7:0] out_width;
    logic [7:0] out_height;
  } res_item_t;

  typedef struct packed {
    logic [7:0] src_width;
    logic [7:0] src_height;
    logic [7:0] dst_width;
    logic [7:0] dst_height;
    logic [1:0] scale_mode;
  } cfg_t;

  // classified work passed from front to back
  typedef struct packed {
    logic        is_load;
    logic [15:0] addr;
    logic [31:0] pixel;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [8:0]  ow;
    logic [8:0]  oh;
    logic [8:0]  sw;
    logic [8:0]  sh;
    logic        blur;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  typedef struct packed {
    logic idle;
  } bk_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_READ,
    BK_FIN,
    BK_EMIT
  } back_state_e;

  // byte divided by five via reciprocal multiply, exact for 8-bit inputs
  function automatic logic [7:0] div5(input logic [7:0] b);
    logic [15:0] p;
    p = {8'd0, b} * 16'd205;
    return 8'(p >> 10);
  endfunction

endpackage

// ===== rtl/image_resize_nearest_and_box_blur.sv =====
// top level of the nearest-neighbor image scaler with five-point blur
//
//  channel   handshake            payload
//  request   start && !busy       in_i (func, pixel_word)
//  result    done_o, one cycle    result_o (bytes, last_pixel, out size)
//  config    cfg_we_i             cfg_idx_i, cfg_wdata_i
//
// a load request is written into the store in the cycle it leaves the queue
// an output request runs one multiply, a 16-step restoring divide per coordinate,
// then one or five reads of the single-port store
// two requests can wait in the queue; busy is high while it is full
// the result strobe lasts one cycle and the receiver cannot stall it
// reset clears counters and control; the store holds no reset value
`include "image_resize_nearest_and_box_blur_defines.svh"
module image_resize_nearest_and_box_blur (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  irnbb_pkg::in_item_t   in_i,
  output logic                  done_o,
  output irnbb_pkg::res_item_t  result_o,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [7:0]            cfg_wdata_i
);
  import irnbb_pkg::*;

  cfg_t         cfg_q;
  logic         accept, push, pop;
  cmd_t         cmd_w, cmd_r;
  fifo_status_t fifo_stat;
  bk_status_t   bk_stat;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_width  <= 8'd1;
      cfg_q.src_height <= 8'd1;
      cfg_q.dst_width  <= 8'd1;
      cfg_q.dst_height <= 8'd1;
      cfg_q.scale_mode <= MODE_NEAREST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SRC_W: cfg_q.src_width  <= cfg_wdata_i;
        CFG_SRC_H: cfg_q.src_height <= cfg_wdata_i;
        CFG_DST_W: cfg_q.dst_width  <= cfg_wdata_i;
        CFG_DST_H: cfg_q.dst_height <= cfg_wdata_i;
        CFG_MODE:  cfg_q.scale_mode <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  assign busy   = fifo_stat.full;
  assign accept = start && !busy;

  irnbb_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_i),
    .cfg_i    (cfg_q),
    .push_o   (push),
    .cmd_o    (cmd_w)
  );

  irnbb_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  (cmd_w),
    .pop_i    (pop),
    .rdata_o  (cmd_r),
    .status_o (fifo_stat)
  );

  irnbb_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_r),
    .fifo_i   (fifo_stat),
    .pop_o    (pop),
    .status_o (bk_stat),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // checks
  `IRNBB_ASSERT_NEXT(a_strobe_single, done_o, !done_o, "result strobe held two cycles")
  `IRNBB_ASSERT_NEXT(a_idle_no_result, bk_stat.idle, !done_o, "result from idle back end")
  `IRNBB_ASSERT_NOW(a_pop_nonempty, pop, !fifo_stat.empty, "pop from empty queue")

endmodule

// ===== rtl/irnbb_front.sv =====
// front end: request accept, load index and output position tracking
module irnbb_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  irnbb_pkg::in_item_t in_i,
  input  irnbb_pkg::cfg_t    cfg_i,
  output logic               push_o,
  output irnbb_pkg::cmd_t    cmd_o
);
  import irnbb_pkg::*;

  logic [15:0] load_idx_q, load_idx_d;
  logic [7:0]  row_q, row_d, col_q, col_d;
  logic [8:0]  sw, sh, dw, dh, ow, oh, pot, half;
  logic [15:0] limit, idx;
  logic [16:0] idx_nxt;
  logic [7:0]  r, c;
  logic [8:0]  c1, r1;
  logic        last;

  // clamp a dimension register to the usable range
  function automatic logic [8:0] eff_dim(input logic [7:0] v);
    if (v == 8'd0) return 9'd1;
    if (32'(v) > MAX_DIM) return 9'(MAX_DIM);
    return {1'b0, v};
  endfunction

  assign sw = eff_dim(cfg_i.src_width);
  assign sh = eff_dim(cfg_i.src_height);
  assign dw = eff_dim(cfg_i.dst_width);
  assign dh = eff_dim(cfg_i.dst_height);

  // mean side rounded up to a power of two, saturated
  always_comb begin
    logic [9:0] sum;
    logic [8:0] s;
    sum  = {1'b0, sw} + {1'b0, sh};
    half = sum[9:1];
    s    = 9'd1;
    for (int i = 0; i < 8; i++) begin
      if ((9'd1 << i) < half) s = 9'd1 << (i + 1);
    end
    pot = (32'(s) > MAX_DIM) ? 9'(MAX_DIM) : s;
  end

  // effective output size
  always_comb begin
    if (cfg_i.scale_mode == MODE_POT) begin
      if ((sw == sh) && ((sw & (sw - 9'd1)) == 9'd0)) begin
        ow = sw;
        oh = sh;
      end else begin
        ow = pot;
        oh = pot;
      end
    end else begin
      ow = dw;
      oh = dh;
    end
  end

  // load index wrap
  assign limit   = 16'(sw * sh);
  assign idx     = (load_idx_q >= limit) ? 16'd0 : load_idx_q;
  assign idx_nxt = {1'b0, idx} + 17'd1;

  // output position restart and advance
  always_comb begin
    if ({1'b0, row_q} >= oh || {1'b0, col_q} >= ow) begin
      r = 8'd0;
      c = 8'd0;
    end else begin
      r = row_q;
      c = col_q;
    end
    last = ({1'b0, r} == oh - 9'd1) && ({1'b0, c} == ow - 9'd1);
    c1   = {1'b0, c} + 9'd1;
    r1   = {1'b0, r} + 9'd1;
  end

  // next counter values
  always_comb begin
    load_idx_d = load_idx_q;
    row_d      = row_q;
    col_d      = col_q;
    if (accept_i) begin
      if (in_i.func == FUNC_LOAD) begin
        load_idx_d = (idx_nxt >= {1'b0, limit}) ? 16'd0 : idx_nxt[15:0];
      end else if (c1 >= ow) begin
        col_d = 8'd0;
        row_d = (r1 >= oh) ? 8'd0 : r1[7:0];
      end else begin
        col_d = c1[7:0];
        row_d = r;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_idx_q <= 16'd0;
      row_q      <= 8'd0;
      col_q      <= 8'd0;
    end else begin
      load_idx_q <= load_idx_d;
      row_q      <= row_d;
      col_q      <= col_d;
    end
  end

  // command toward the back end
  assign push_o = accept_i;
  always_comb begin
    cmd_o.is_load = (in_i.func == FUNC_LOAD);
    cmd_o.addr    = idx;
    cmd_o.pixel   = in_i.pixel_word;
    cmd_o.row     = r;
    cmd_o.col     = c;
    cmd_o.ow      = ow;
    cmd_o.oh      = oh;
    cmd_o.sw      = sw;
    cmd_o.sh      = sh;
    cmd_o.blur    = (cfg_i.scale_mode == MODE_BLUR);
    cmd_o.last    = last;
  end

endmodule

// ===== rtl/irnbb_fifo.sv =====
// short command queue between front and back
module irnbb_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  irnbb_pkg::cmd_t        wdata_i,
  input  logic                   pop_i,
  output irnbb_pkg::cmd_t        rdata_o,
  output irnbb_pkg::fifo_status_t status_o
);
  import irnbb_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  cmd_t          ent_q [FIFO_DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;

  assign status_o.full  = (cnt_q == CW'(FIFO_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign rdata_o        = ent_q[rp_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wp_q] <= wdata_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= PW'(wp_q + 1'b1);
      if (pop_i)  rp_q <= PW'(rp_q + 1'b1);
      if (push_i && !pop_i) cnt_q <= CW'(cnt_q + 1'b1);
      else if (pop_i && !push_i) cnt_q <= CW'(cnt_q - 1'b1);
    end
  end

endmodule

// ===== rtl/irnbb_back.sv =====
// back end: source store, coordinate division, tap reads and result
module irnbb_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  irnbb_pkg::cmd_t         cmd_i,
  input  irnbb_pkg::fifo_status_t fifo_i,
  output logic                    pop_o,
  output irnbb_pkg::bk_status_t   status_o,
  output logic                    done_o,
  output irnbb_pkg::res_item_t    result_o
);
  import irnbb_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  back_state_e state_q, state_d;
  cmd_t        cmd_q;
  logic [15:0] ny_q, nx_q, qy_q, qx_q;
  logic [8:0]  ry_q, rx_q;
  logic [3:0]  cnt_q;
  logic [2:0]  tap_q;
  logic        rdp_q, rd_en, wr_en, last_tap;
  logic [31:0] mem_q [DEPTH];
  logic [31:0] rd_q, acc_q;
  logic [AW-1:0] ra;
  logic [9:0]  ty, tx;
  logic [8:0]  ry_d, rx_d;
  logic        by, bx;
  logic [7:0]  sy, sx, ym, yp, xm, xp, trow, tcol;
  logic [16:0] taddr;
  logic        done_q;
  res_item_t   res_q;

  // restoring division step for both coordinates
  always_comb begin
    ty = {ry_q, ny_q[15]};
    tx = {rx_q, nx_q[15]};
    by = (ty >= {1'b0, cmd_q.oh});
    bx = (tx >= {1'b0, cmd_q.ow});
    ry_d = by ? 9'(ty - {1'b0, cmd_q.oh}) : ty[8:0];
    rx_d = bx ? 9'(tx - {1'b0, cmd_q.ow}) : tx[8:0];
  end

  // tap coordinates with edge clamping
  always_comb begin
    sy = qy_q[7:0];
    sx = qx_q[7:0];
    ym = (sy == 8'd0) ? sy : sy - 8'd1;
    xm = (sx == 8'd0) ? sx : sx - 8'd1;
    yp = ({1'b0, sy} == cmd_q.sh - 9'd1) ? sy : sy + 8'd1;
    xp = ({1'b0, sx} == cmd_q.sw - 9'd1) ? sx : sx + 8'd1;
    case (tap_q)
      3'd1:    begin trow = ym; tcol = xm; end
      3'd2:    begin trow = ym; tcol = xp; end
      3'd3:    begin trow = yp; tcol = xm; end
      3'd4:    begin trow = yp; tcol = xp; end
      default: begin trow = sy; tcol = sx; end
    endcase
    taddr = 17'(trow * cmd_q.sw) + {9'd0, tcol};
    ra    = AW'(taddr);
  end

  assign last_tap = cmd_q.blur ? (tap_q == 3'(NUM_TAPS - 1)) : 1'b1;

  // sequencer
  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!fifo_i.empty) begin
          pop_o = 1'b1;
          if (cmd_i.is_load) wr_en = 1'b1;
          else state_d = BK_MUL;
        end
      end
      BK_MUL:  state_d = BK_DIV;
      BK_DIV:  if (cnt_q == 4'd15) state_d = BK_READ;
      BK_READ: begin
        rd_en = 1'b1;
        if (last_tap) state_d = BK_FIN;
      end
      BK_FIN:  state_d = BK_EMIT;
      BK_EMIT: state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= BK_IDLE;
    else state_q <= state_d;
  end

  // source store, single port
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[AW'(cmd_i.addr)] <= cmd_i.pixel;
    if (rd_en) rd_q <= mem_q[ra];
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (pop_o && !cmd_i.is_load) cmd_q <= cmd_i;
    case (state_q)
      BK_MUL: begin
        ny_q  <= 16'(cmd_q.row * cmd_q.sh);
        nx_q  <= 16'(cmd_q.col * cmd_q.sw);
        ry_q  <= 9'd0;
        rx_q  <= 9'd0;
        cnt_q <= 4'd0;
        tap_q <= 3'd0;
        acc_q <= 32'd0;
      end
      BK_DIV: begin
        ny_q  <= {ny_q[14:0], 1'b0};
        nx_q  <= {nx_q[14:0], 1'b0};
        ry_q  <= ry_d;
        rx_q  <= rx_d;
        qy_q  <= {qy_q[14:0], by};
        qx_q  <= {qx_q[14:0], bx};
        cnt_q <= cnt_q + 4'd1;
      end
      BK_READ: tap_q <= tap_q + 3'd1;
      default: ;
    endcase
    // accumulate returning tap data
    if (rdp_q) begin
      if (cmd_q.blur) begin
        for (int k = 0; k < 4; k++) begin
          acc_q[8*k +: 8] <= acc_q[8*k +: 8] + div5(rd_q[8*k +: 8]);
        end
      end else begin
        acc_q <= rd_q;
      end
    end
    if (state_q == BK_EMIT) begin
      res_q.byte0      <= acc_q[7:0];
      res_q.byte1      <= acc_q[15:8];
      res_q.byte2      <= acc_q[23:16];
      res_q.byte3      <= acc_q[31:24];
      res_q.last_pixel <= cmd_q.last;
      res_q.out_width  <= cmd_q.ow[7:0];
      res_q.out_height <= cmd_q.oh[7:0];
    end
  end

  // read pending flag and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdp_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      rdp_q  <= rd_en;
      done_q <= (state_q == BK_EMIT);
    end
  end

  assign done_o        = done_q;
  assign result_o      = res_q;
  assign status_o.idle = (state_q == BK_IDLE);

endmodule
